FILE: hw/rtl/icmp_erm_pkg.sv
// Shared types and constants for the ICMP echo reply matcher.
package icmp_erm_pkg;

    localparam int ByteW   = 8;
    localparam int PosW    = 7;
    localparam int HdrW    = 6;
    localparam int CfgW    = 16;
    localparam int OutW    = 8;

    localparam logic [PosW-1:0] PosMax     = 7'd127;
    localparam logic [PosW-1:0] MinIpLen   = 7'd20;
    localparam logic [PosW-1:0] IcmpHdrLen = 7'd8;
    localparam logic [3:0]      VersionIp4 = 4'd4;

    localparam logic [PosW-1:0] OffType  = 7'd0;
    localparam logic [PosW-1:0] OffCode  = 7'd1;
    localparam logic [PosW-1:0] OffIdHi  = 7'd4;
    localparam logic [PosW-1:0] OffIdLo  = 7'd5;
    localparam logic [PosW-1:0] OffSeqHi = 7'd6;
    localparam logic [PosW-1:0] OffSeqLo = 7'd7;

    typedef enum logic [0:0] {
        CFG_IDENTIFIER = 1'b0,
        CFG_SEQUENCE   = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
    } t_beat;

endpackage

FILE: hw/rtl/icmp_erm_in_stage.sv
// Input register stage that holds one accepted packet beat.
module icmp_erm_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  icmp_erm_pkg::t_beat  i_beat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output icmp_erm_pkg::t_beat  o_beat
);

    logic                r_valid;
    icmp_erm_pkg::t_beat r_beat;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

endmodule

FILE: hw/rtl/icmp_erm_core.sv
// Per-packet header tracking, field compare and verdict register.
module icmp_erm_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  icmp_erm_pkg::t_cfg_index            i_cfg_index,
    input  logic [icmp_erm_pkg::CfgW-1:0]       i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  icmp_erm_pkg::t_beat                 i_beat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_matched
);

    logic [icmp_erm_pkg::CfgW-1:0] r_ident;
    logic [icmp_erm_pkg::CfgW-1:0] r_seq;

    logic [icmp_erm_pkg::PosW-1:0] r_pos, n_pos;
    logic [icmp_erm_pkg::HdrW-1:0] r_hdr, n_hdr;
    logic                          r_ver, n_ver;
    logic                          r_fields, n_fields;
    logic                          r_out_valid, n_out_valid;
    logic                          r_matched, n_matched;

    logic [icmp_erm_pkg::PosW-1:0]  u_pos;
    logic [icmp_erm_pkg::HdrW-1:0]  u_hdr;
    logic                           u_ver;
    logic                           u_fields;
    logic [icmp_erm_pkg::PosW-1:0]  k;
    logic [icmp_erm_pkg::ByteW-1:0] want;
    logic                           check;
    logic                           match;
    logic                           fire;

    assign o_ready     = !i_beat.last || !r_out_valid || i_out_ready;
    assign fire        = i_valid && o_ready;
    assign o_out_valid = r_out_valid;
    assign o_matched   = r_matched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ident <= '0;
            r_seq   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                icmp_erm_pkg::CFG_IDENTIFIER: r_ident <= i_cfg_data;
                icmp_erm_pkg::CFG_SEQUENCE:   r_seq   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        k     = r_pos - {1'b0, r_hdr};
        want  = '0;
        check = 1'b1;
        case (k) inside
            icmp_erm_pkg::OffType, icmp_erm_pkg::OffCode: want = '0;
            icmp_erm_pkg::OffIdHi:  want = r_ident[15:8];
            icmp_erm_pkg::OffIdLo:  want = r_ident[7:0];
            icmp_erm_pkg::OffSeqHi: want = r_seq[15:8];
            icmp_erm_pkg::OffSeqLo: want = r_seq[7:0];
            default:                check = 1'b0;
        endcase

        u_ver    = r_ver;
        u_hdr    = r_hdr;
        u_fields = r_fields;
        if (r_pos == '0) begin
            u_ver = i_beat.data[7:4] == icmp_erm_pkg::VersionIp4;
            u_hdr = {i_beat.data[3:0], 2'b00};
        end else if (r_pos < icmp_erm_pkg::PosMax && r_pos >= {1'b0, r_hdr}) begin
            if (check && i_beat.data != want) begin
                u_fields = 1'b0;
            end
        end
        u_pos = (r_pos == icmp_erm_pkg::PosMax) ? r_pos : r_pos + 7'd1;

        match = u_pos >= icmp_erm_pkg::MinIpLen
             && u_ver
             && {1'b0, u_hdr} >= icmp_erm_pkg::MinIpLen
             && u_pos >= {1'b0, u_hdr} + icmp_erm_pkg::IcmpHdrLen
             && u_fields;

        n_pos       = r_pos;
        n_hdr       = r_hdr;
        n_ver       = r_ver;
        n_fields    = r_fields;
        n_out_valid = r_out_valid && !i_out_ready;
        n_matched   = r_matched;
        if (fire) begin
            if (i_beat.last) begin
                n_pos       = '0;
                n_hdr       = '0;
                n_ver       = 1'b0;
                n_fields    = 1'b1;
                n_out_valid = 1'b1;
                n_matched   = match;
            end else begin
                n_pos    = u_pos;
                n_hdr    = u_hdr;
                n_ver    = u_ver;
                n_fields = u_fields;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_hdr       <= '0;
            r_ver       <= 1'b0;
            r_fields    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_hdr       <= n_hdr;
            r_ver       <= n_ver;
            r_fields    <= n_fields;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_matched <= n_matched;
    end

`ifndef SYNTHESIS
    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !i_beat.last && r_pos != icmp_erm_pkg::PosMax
        |=> r_pos == $past(r_pos) + 7'd1)
        else $error("byte position did not advance");

    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_beat.last |=> r_pos == '0 && r_fields && !r_ver)
        else $error("packet state not cleared after last beat");

    a_verdict_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_beat.last |=> r_out_valid)
        else $error("verdict not registered after last beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_beat.last |-> !r_out_valid || i_out_ready)
        else $error("pending verdict overwritten");
`endif

endmodule

FILE: hw/rtl/icmp_echo_reply_matcher.sv
// Top level of the ICMP echo reply matcher: input stage and verdict core.
// Throughput: one packet byte per cycle; a final byte stalls the input while the
// previous verdict is still unread. The final byte's beat passes the input register
// first; the verdict register loads when the core accepts it from there.
// Reset: synchronous active-low; clears packet state, valid flags and both
// expected-value registers to zero.
module icmp_echo_reply_matcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [icmp_erm_pkg::CfgW-1:0]       i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [icmp_erm_pkg::ByteW-1:0]      i_s_tdata,   // [7:0] packet_byte
    input  logic                                i_s_tlast,   // end_of_packet
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [icmp_erm_pkg::OutW-1:0]       o_m_tdata    // [0] reply_matched, [7:1] zero
);

    icmp_erm_pkg::t_beat in_beat;
    icmp_erm_pkg::t_beat st_beat;
    logic                st_valid;
    logic                st_ready;
    logic                matched;

    assign in_beat.data = i_s_tdata;
    assign in_beat.last = i_s_tlast;

    icmp_erm_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_beat  (in_beat),
        .o_valid (st_valid),
        .i_ready (st_ready),
        .o_beat  (st_beat)
    );

    icmp_erm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (icmp_erm_pkg::t_cfg_index'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (st_valid),
        .o_ready     (st_ready),
        .i_beat      (st_beat),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_matched   (matched)
    );

    assign o_m_tdata = {{(icmp_erm_pkg::OutW-1){1'b0}}, matched};

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the ICMP echo reply matcher: packet stimulus, verdict prediction, compare.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit  = 400000;
    localparam int RandomBytes = 360;
    localparam int Phases      = 6;
    localparam int LongHold    = 400;

    typedef enum int {
        SPOIL_NONE,
        SPOIL_TYPE,
        SPOIL_CODE,
        SPOIL_ID_HI,
        SPOIL_ID_LO,
        SPOIL_SEQ_HI,
        SPOIL_SEQ_LO
    } t_spoil;

    typedef enum int {
        VERDICT_ZERO,
        VERDICT_ONE,
        VERDICT_MODEL
    } t_verdict_src;

    typedef struct {
        logic [3:0]   ver;
        logic [3:0]   ihl;
        int           len;
        t_spoil       spoil;
        t_verdict_src src;
    } t_case;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    icmp_erm_pkg::t_cfg_index cfg_index = icmp_erm_pkg::CFG_IDENTIFIER;
    logic [icmp_erm_pkg::CfgW-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [icmp_erm_pkg::ByteW-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [icmp_erm_pkg::OutW-1:0] m_tdata;

    // verdict predictor state
    logic [icmp_erm_pkg::PosW-1:0] seen_bytes;
    logic [icmp_erm_pkg::HdrW-1:0] ip_hdr_len;
    bit                            ip_v4;
    bit                            icmp_ok;
    logic [icmp_erm_pkg::CfgW-1:0] want_id;
    logic [icmp_erm_pkg::CfgW-1:0] want_seq;

    logic [icmp_erm_pkg::OutW-1:0]  verdict_q[$];
    logic [icmp_erm_pkg::ByteW-1:0] pkt[$];

    int  errors = 0;
    int  cycles = 0;
    int  sent_bytes = 0;
    int  send_burst = 0;
    int  recv_burst = 0;
    bit  rush = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    t_case directed_cases [20] = '{
        '{4'd4,  4'd5,  28,  SPOIL_NONE,   VERDICT_ONE},
        '{4'd4,  4'd5,  27,  SPOIL_NONE,   VERDICT_ZERO},
        '{4'd4,  4'd5,  19,  SPOIL_NONE,   VERDICT_ZERO},
        '{4'd4,  4'd5,  1,   SPOIL_NONE,   VERDICT_ZERO},
        '{4'd6,  4'd5,  28,  SPOIL_NONE,   VERDICT_ZERO},
        '{4'd4,  4'd4,  28,  SPOIL_NONE,   VERDICT_ZERO},
        '{4'd4,  4'd0,  40,  SPOIL_NONE,   VERDICT_ZERO},
        '{4'd4,  4'd15, 68,  SPOIL_NONE,   VERDICT_ONE},
        '{4'd4,  4'd15, 67,  SPOIL_NONE,   VERDICT_ZERO},
        '{4'd4,  4'd5,  200, SPOIL_NONE,   VERDICT_ONE},
        '{4'd4,  4'd15, 255, SPOIL_NONE,   VERDICT_MODEL},
        '{4'd4,  4'd5,  36,  SPOIL_TYPE,   VERDICT_ZERO},
        '{4'd4,  4'd5,  36,  SPOIL_CODE,   VERDICT_ZERO},
        '{4'd4,  4'd5,  36,  SPOIL_ID_HI,  VERDICT_ZERO},
        '{4'd4,  4'd5,  36,  SPOIL_ID_LO,  VERDICT_ZERO},
        '{4'd4,  4'd5,  36,  SPOIL_SEQ_HI, VERDICT_ZERO},
        '{4'd4,  4'd5,  36,  SPOIL_SEQ_LO, VERDICT_ZERO},
        '{4'd15, 4'd15, 30,  SPOIL_NONE,   VERDICT_ZERO},
        '{4'd4,  4'd6,  60,  SPOIL_NONE,   VERDICT_MODEL},
        '{4'd4,  4'd7,  35,  SPOIL_ID_LO,  VERDICT_MODEL}
    };

    icmp_echo_reply_matcher DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void clear_packet_state();
        seen_bytes = '0;
        ip_hdr_len = '0;
        ip_v4      = 1'b0;
        icmp_ok    = 1'b1;
    endfunction

    function automatic bit match_step(input logic [icmp_erm_pkg::ByteW-1:0] b, input bit last,
                                      output bit verdict);
        logic [icmp_erm_pkg::PosW-1:0]  k;
        logic [icmp_erm_pkg::ByteW-1:0] want;
        bit                             chk;
        verdict = 1'b0;
        if (seen_bytes == '0) begin
            ip_v4      = (b[7:4] == icmp_erm_pkg::VersionIp4);
            ip_hdr_len = {b[3:0], 2'b00};
        end else if (seen_bytes < icmp_erm_pkg::PosMax
                     && seen_bytes >= {1'b0, ip_hdr_len}) begin
            k    = seen_bytes - {1'b0, ip_hdr_len};
            want = '0;
            chk  = 1'b1;
            case (k)
                icmp_erm_pkg::OffType, icmp_erm_pkg::OffCode: want = '0;
                icmp_erm_pkg::OffIdHi:  want = want_id[15:8];
                icmp_erm_pkg::OffIdLo:  want = want_id[7:0];
                icmp_erm_pkg::OffSeqHi: want = want_seq[15:8];
                icmp_erm_pkg::OffSeqLo: want = want_seq[7:0];
                default:                chk = 1'b0;
            endcase
            if (chk && b != want) begin
                icmp_ok = 1'b0;
            end
        end
        if (seen_bytes < icmp_erm_pkg::PosMax) begin
            seen_bytes = seen_bytes + 1'b1;
        end
        if (!last) begin
            return 1'b0;
        end
        verdict = seen_bytes >= icmp_erm_pkg::MinIpLen && ip_v4
                  && {1'b0, ip_hdr_len} >= icmp_erm_pkg::MinIpLen
                  && seen_bytes >= {1'b0, ip_hdr_len} + icmp_erm_pkg::IcmpHdrLen
                  && icmp_ok;
        clear_packet_state();
        return 1'b1;
    endfunction

    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic build_packet(input logic [3:0] ver, input logic [3:0] ihl, input int len,
                                input logic [15:0] id, input logic [15:0] seq,
                                input t_spoil spoil);
        int                             hdr;
        int                             idx;
        int                             off;
        logic [icmp_erm_pkg::PosW-1:0]  k;
        logic [icmp_erm_pkg::ByteW-1:0] b;
        hdr = int'(ihl) * 4;
        pkt.delete();
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (i == 0) begin
                b = {ver, ihl};
            end else if (i >= hdr && i - hdr < 8) begin
                off = i - hdr;
                k   = off[icmp_erm_pkg::PosW-1:0];
                case (k)
                    icmp_erm_pkg::OffType, icmp_erm_pkg::OffCode: b = '0;
                    icmp_erm_pkg::OffIdHi:  b = id[15:8];
                    icmp_erm_pkg::OffIdLo:  b = id[7:0];
                    icmp_erm_pkg::OffSeqHi: b = seq[15:8];
                    icmp_erm_pkg::OffSeqLo: b = seq[7:0];
                    default:                b = 8'($urandom);
                endcase
            end
            pkt.push_back(b);
        end
        if (spoil != SPOIL_NONE) begin
            case (spoil)
                SPOIL_TYPE:   k = icmp_erm_pkg::OffType;
                SPOIL_CODE:   k = icmp_erm_pkg::OffCode;
                SPOIL_ID_HI:  k = icmp_erm_pkg::OffIdHi;
                SPOIL_ID_LO:  k = icmp_erm_pkg::OffIdLo;
                SPOIL_SEQ_HI: k = icmp_erm_pkg::OffSeqHi;
                default:      k = icmp_erm_pkg::OffSeqLo;
            endcase
            idx = hdr + int'(k);
            if (idx > 0 && idx < len) begin
                pkt[idx] = pkt[idx] ^ 8'($urandom_range(1, 255));
            end
        end
    endtask

    task automatic send_beat(input logic [icmp_erm_pkg::ByteW-1:0] b, input bit last);
        int gap;
        gap = rush ? 0 : draw_gap(send_burst);
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        sent_bytes++;
    endtask

    task automatic send_packet(input t_verdict_src src);
        bit has;
        bit v;
        for (int i = 0; i < pkt.size(); i++) begin
            send_beat(pkt[i], i == pkt.size() - 1);
            has = match_step(pkt[i], i == pkt.size() - 1, v);
            if (has) begin
                if (src == VERDICT_ONE) begin
                    v = 1'b1;
                end else if (src == VERDICT_ZERO) begin
                    v = 1'b0;
                end
                verdict_q.push_back({{(icmp_erm_pkg::OutW-1){1'b0}}, v});
            end
        end
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input icmp_erm_pkg::t_cfg_index idx,
                             input logic [icmp_erm_pkg::CfgW-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == icmp_erm_pkg::CFG_IDENTIFIER) begin
            want_id = val;
        end else begin
            want_seq = val;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        foreach (directed_cases[i]) begin
            build_packet(directed_cases[i].ver, directed_cases[i].ihl, directed_cases[i].len,
                         want_id, want_seq, directed_cases[i].spoil);
            send_packet(directed_cases[i].src);
        end
    endtask

    task automatic random_packet();
        int         kind;
        int         len;
        logic [3:0] ver;
        logic [3:0] ihl;
        logic [15:0] id;
        logic [15:0] seq;
        t_spoil     sp;
        kind = $urandom_range(0, 9);
        id   = want_id;
        seq  = want_seq;
        sp   = SPOIL_NONE;
        if (kind <= 5) begin
            ver = icmp_erm_pkg::VersionIp4;
            ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
            len = int'(ihl) * 4 + 8 + $urandom_range(0, 24);
            if ($urandom_range(0, 19) == 0) begin
                len = $urandom_range(127, 180);
            end
            if ($urandom_range(0, 2) == 0) begin
                sp = t_spoil'($urandom_range(1, 6));
            end
            build_packet(ver, ihl, len, id, seq, sp);
        end else if (kind <= 7) begin
            ver = ($urandom_range(0, 3) == 0) ? 4'($urandom) : icmp_erm_pkg::VersionIp4;
            ihl = 4'($urandom);
            len = $urandom_range(1, 80);
            if ($urandom_range(0, 1) == 0) begin
                id = 16'($urandom);
            end
            if ($urandom_range(0, 1) == 0) begin
                seq = 16'($urandom);
            end
            sp = t_spoil'($urandom_range(0, 6));
            build_packet(ver, ihl, len, id, seq, sp);
        end else begin
            len = $urandom_range(1, 40);
            pkt.delete();
            repeat (len) pkt.push_back(8'($urandom));
        end
        send_packet(VERDICT_MODEL);
    endtask

    initial begin
        wait (rst_n);
        forever begin
            int gap;
            logic [icmp_erm_pkg::OutW-1:0] want;
            if (hold_req && !hold_done) begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (LongHold) @(negedge clk);
                hold_done = 1'b1;
            end
            gap = draw_gap(recv_burst);
            if (gap > 0) begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (verdict_q.size() == 0) begin
                $display("%0t: verdict mismatch, expected none, got %0h", $time, m_tdata);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata !== want) begin
                    $display("%0t: verdict mismatch, expected %0h, got %0h",
                             $time, want, m_tdata);
                    errors++;
                end
            end
        end
    end

    initial begin
        int phase_end;
        want_id  = '0;
        want_seq = '0;
        clear_packet_state();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        for (int p = 0; p < Phases; p++) begin
            settle();
            case (p)
                0: begin
                    write_reg(icmp_erm_pkg::CFG_IDENTIFIER, 16'hFFFF);
                    write_reg(icmp_erm_pkg::CFG_SEQUENCE, 16'h0000);
                end
                1: begin
                    write_reg(icmp_erm_pkg::CFG_IDENTIFIER, 16'h0000);
                    write_reg(icmp_erm_pkg::CFG_SEQUENCE, 16'hFFFF);
                end
                default: begin
                    write_reg(icmp_erm_pkg::CFG_IDENTIFIER, 16'($urandom));
                    write_reg(icmp_erm_pkg::CFG_SEQUENCE, 16'($urandom));
                end
            endcase
            if (p == 1) begin
                // back up the verdict path with short packets
                rush     = 1'b1;
                hold_req = 1'b1;
                repeat (40) begin
                    pkt.delete();
                    repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
                    send_packet(VERDICT_MODEL);
                end
                rush = 1'b0;
            end
            phase_end = sent_bytes + RandomBytes / Phases;
            while (sent_bytes < phase_end) begin
                random_packet();
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/icmp_erm_pkg.sv
hw/rtl/icmp_erm_in_stage.sv
hw/rtl/icmp_erm_core.sv
hw/rtl/icmp_echo_reply_matcher.sv
tb/testbench.sv
